// ===== rtl/core/bevwr_pkg.sv =====
// ----------------------------------------------------------------------------
// bevwr_pkg
// Shared types and constants of the big-endian variable-width RAM.
// ----------------------------------------------------------------------------
package bevwr_pkg;

    localparam int ADDR_W           = 18;
    localparam int DATA_W           = 64;
    localparam int CNT_W            = 4;
    localparam int WORD_W           = 32;
    localparam int WORD_BYTES       = 4;
    localparam int WIDX_W           = 16;
    localparam int DEPTH_WORDS      = 1 << WIDX_W;
    localparam int MAX_ACCESS_BYTES = 8;
    localparam int CMDQ_DEPTH       = 2;
    localparam int CMDQ_PTR_W       = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CNT_W       = $clog2(CMDQ_DEPTH + 1);

    typedef enum logic [1:0] {
        AW_VAR  = 2'd0,
        AW_BYTE = 2'd1,
        AW_HALF = 2'd2,
        AW_WORD = 2'd3
    } acc_width_t;

    typedef enum logic {
        FUNC_READ  = 1'b0,
        FUNC_WRITE = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MERGE,
        ST_DONE
    } back_state_t;

    typedef struct packed {
        logic              wr;
        logic [WIDX_W-1:0] widx;
        logic [1:0]        off;
        logic [CNT_W-1:0]  cnt;
        logic [DATA_W-1:0] wdata;
    } cmd_t;

    function automatic logic [WIDX_W-1:0] wrap_idx(input logic [ADDR_W-1:0] v);
        logic [ADDR_W+WIDX_W-1:0] ext;
        ext = (ADDR_W + WIDX_W)'(v);
        return ext[WIDX_W-1:0];
    endfunction

endpackage

// ===== rtl/core/bevwr_ram.sv =====
// ----------------------------------------------------------------------------
// bevwr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bevwr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ===== rtl/core/bevwr_front.sv =====
// ----------------------------------------------------------------------------
// bevwr_front
// Accept bus words and classify them into word index, offset and byte count.
// ----------------------------------------------------------------------------
module bevwr_front (
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            func,
    input  logic [1:0]                      access_width,
    input  logic [bevwr_pkg::ADDR_W-1:0]    address,
    input  logic [bevwr_pkg::CNT_W-1:0]     byte_count,
    input  logic [bevwr_pkg::DATA_W-1:0]    write_data,
    input  logic                            q_full,
    output logic                            q_push,
    output bevwr_pkg::cmd_t                 q_cmd
);
    import bevwr_pkg::*;

    logic [CNT_W-1:0] sat_cnt;
    logic [CNT_W-1:0] cnt;
    logic [6:0]       align_sh;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    assign sat_cnt = (byte_count > CNT_W'(MAX_ACCESS_BYTES)) ?
                     CNT_W'(MAX_ACCESS_BYTES) : byte_count;

    always_comb
    begin
        q_cmd.wr = (func_t'(func) == FUNC_WRITE);
        unique case (acc_width_t'(access_width))
            AW_VAR:
            begin
                q_cmd.widx = wrap_idx(address >> 2);
                q_cmd.off  = address[1:0];
                cnt        = sat_cnt;
            end
            AW_BYTE:
            begin
                q_cmd.widx = wrap_idx(address >> 2);
                q_cmd.off  = address[1:0];
                cnt        = CNT_W'(1);
            end
            AW_HALF:
            begin
                q_cmd.widx = wrap_idx(address >> 1);
                q_cmd.off  = {address[0], 1'b0};
                cnt        = CNT_W'(2);
            end
            AW_WORD:
            begin
                q_cmd.widx = wrap_idx(address);
                q_cmd.off  = 2'd0;
                cnt        = CNT_W'(WORD_BYTES);
            end
            default:
            begin
                q_cmd.widx = '0;
                q_cmd.off  = 2'd0;
                cnt        = '0;
            end
        endcase
        q_cmd.cnt   = cnt;
        // left-align so the first byte sits on top
        align_sh    = {4'd8 - cnt, 3'b000};
        q_cmd.wdata = write_data << align_sh;
    end

endmodule

// ===== rtl/core/bevwr_cmdq.sv =====
// ----------------------------------------------------------------------------
// bevwr_cmdq
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module bevwr_cmdq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  bevwr_pkg::cmd_t push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output bevwr_pkg::cmd_t head_cmd
);
    import bevwr_pkg::*;

    cmd_t                  q_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wptr_reg;
    logic [CMDQ_PTR_W-1:0] wptr_next;
    logic [CMDQ_PTR_W-1:0] rptr_reg;
    logic [CMDQ_PTR_W-1:0] rptr_next;
    logic [CMDQ_CNT_W-1:0] count_reg;
    logic [CMDQ_CNT_W-1:0] count_next;
    logic                  do_pop;

    assign full       = (count_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = q_reg[rptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wptr_reg] <= push_cmd;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("cmdq: push while full");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CMDQ_CNT_W'(CMDQ_DEPTH))
        else $error("cmdq: count out of range");
`endif

endmodule

// ===== rtl/core/bevwr_back.sv =====
// ----------------------------------------------------------------------------
// bevwr_back
// Execute queued accesses word by word: read, merge, write back, collect.
// ----------------------------------------------------------------------------
module bevwr_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            head_valid,
    input  bevwr_pkg::cmd_t                 head_cmd,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [bevwr_pkg::DATA_W-1:0]    read_data
);
    import bevwr_pkg::*;

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [WIDX_W-1:0] widx_reg;
    logic [WIDX_W-1:0] widx_next;
    logic [1:0]        off_reg;
    logic [1:0]        off_next;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  rem_next;
    logic              wr_reg;
    logic              wr_next;
    logic [DATA_W-1:0] wsh_reg;
    logic [DATA_W-1:0] wsh_next;
    logic [DATA_W-1:0] rd_reg;
    logic [DATA_W-1:0] rd_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] read_data_reg;
    logic [DATA_W-1:0] read_data_next;

    logic              ram_we;
    logic [WIDX_W-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    logic [WORD_W-1:0] ram_wdata;

    logic [2:0]        avail;
    logic [2:0]        take;
    logic [2:0]        lane_end;
    logic [WORD_W-1:0] lane_mask;
    logic [WORD_W-1:0] seg;
    logic [WORD_W-1:0] wr_lanes;

    bevwr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (widx_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        avail     = 3'd4 - 3'(off_reg);
        take      = (rem_reg < CNT_W'(avail)) ? rem_reg[2:0] : avail;
        lane_end  = 3'(off_reg) + take;
        lane_mask = (32'hFFFF_FFFF >> {off_reg, 3'b000}) &
                    ~(32'hFFFF_FFFF >> {lane_end, 3'b000});
        wr_lanes  = wsh_reg[DATA_W-1 -: WORD_W] >> {off_reg, 3'b000};
        ram_wdata = (ram_rdata & ~lane_mask) | (wr_lanes & lane_mask);
        seg       = ram_rdata << {off_reg, 3'b000};
    end

    always_comb
    begin
        state_next     = state_reg;
        widx_next      = widx_reg;
        off_next       = off_reg;
        rem_next       = rem_reg;
        wr_next        = wr_reg;
        wsh_next       = wsh_reg;
        rd_next        = rd_reg;
        read_data_next = read_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        pop            = 1'b0;
        ram_we         = 1'b0;
        ram_raddr      = widx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                ram_raddr = head_cmd.widx;
                if (head_valid)
                begin
                    pop       = 1'b1;
                    widx_next = head_cmd.widx;
                    off_next  = head_cmd.off;
                    rem_next  = head_cmd.cnt;
                    wr_next   = head_cmd.wr;
                    wsh_next  = head_cmd.wdata;
                    rd_next   = '0;
                    if (head_cmd.cnt != '0)
                    begin
                        state_next = ST_MERGE;
                    end
                    else if (!head_cmd.wr)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MERGE:
            begin
                ram_we   = wr_reg;
                rem_next = rem_reg - CNT_W'(take);
                rd_next  = (rd_reg << {take, 3'b000}) |
                           DATA_W'(seg >> {2'(3'd4 - take), 3'b000});
                if (rem_next != '0)
                begin
                    widx_next = widx_reg + 1'b1;
                    ram_raddr = widx_next;
                    off_next  = 2'd0;
                    wsh_next  = wsh_reg << {take, 3'b000};
                end
                else if (wr_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    read_data_next = rd_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        widx_reg      <= widx_next;
        off_reg       <= off_next;
        rem_reg       <= rem_next;
        wr_reg        <= wr_next;
        wsh_reg       <= wsh_next;
        rd_reg        <= rd_next;
        read_data_reg <= read_data_next;
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;

`ifndef SYNTHESIS
    a_merge_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MERGE |-> rem_reg != '0)
        else $error("back: merge with no bytes left");

    a_done_is_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE |-> !wr_reg)
        else $error("back: write reached result state");

    a_word_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MERGE && rem_next != '0) |=>
            (state_reg == ST_MERGE && widx_reg == $past(widx_reg) + 1'b1))
        else $error("back: word index did not advance");
`endif

endmodule

// ===== rtl/core/big_endian_variable_width_ram_top.sv =====
// ----------------------------------------------------------------------------
// big_endian_variable_width_ram_top
// Big-endian 32-bit word RAM with byte, halfword, word and variable access.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one access word: func, access_width,
// address, byte_count and write_data. A read gives one word on the output
// channel (out_valid/out_ready) with read_data right-aligned; a write gives
// none. A variable access moves 0 to 8 bytes and may touch up to three words.
// The back end pops an access in ST_IDLE, merges each touched word in ST_MERGE
// on the single RAM read/write port pair (skipped for a zero count), and for
// a read loads the output register in ST_DONE. It starts the next access
// only when the last one is through.
// A two-entry command queue lets the input keep accepting while the back end
// works or while a result waits; in_ready drops when the queue is full.
// When the receiver stalls, the result holds in the output register and the
// back end waits before delivering the next read result.
// Reset clears the queue, the sequencer and the output valid; the RAM holds
// no defined contents until written.
// ----------------------------------------------------------------------------
module big_endian_variable_width_ram_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            func,
    input  logic [1:0]                      access_width,
    input  logic [bevwr_pkg::ADDR_W-1:0]    address,
    input  logic [bevwr_pkg::CNT_W-1:0]     byte_count,
    input  logic [bevwr_pkg::DATA_W-1:0]    write_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [bevwr_pkg::DATA_W-1:0]    read_data
);
    import bevwr_pkg::*;

    logic q_full;
    logic q_push;
    cmd_t q_cmd;
    logic q_pop;
    logic q_head_valid;
    cmd_t q_head_cmd;

    bevwr_front u_front (
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .access_width (access_width),
        .address      (address),
        .byte_count   (byte_count),
        .write_data   (write_data),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (q_cmd)
    );

    bevwr_cmdq u_cmdq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    bevwr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_data  (read_data)
    );

endmodule

// ===== bench/bevwr_check.sv =====
// ----------------------------------------------------------------------------
// bevwr_check
// Watches both channels of the big-endian RAM, predicts and compares reads.
// ----------------------------------------------------------------------------
// Every accepted access word updates a private image of the 32-bit word store.
// Bytes are held big-endian, and all byte addresses wrap at 18 bits. A read
// queues its right-aligned value. Each word taken from the output channel is
// compared with the oldest queued value. The checker reports the failure
// count, the number of reads still outstanding and the number checked.
// ----------------------------------------------------------------------------
module bevwr_check
    import bevwr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 func,
    input  logic [1:0]           access_width,
    input  logic [ADDR_W-1:0]    address,
    input  logic [CNT_W-1:0]     byte_count,
    input  logic [DATA_W-1:0]    write_data,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [DATA_W-1:0]    read_data,
    output int                   fail_count,
    output int                   pending,
    output int                   results_checked
);

    bit   [WORD_W-1:0] ram_image [DEPTH_WORDS];
    logic [DATA_W-1:0] expected_reads [$];

    function automatic logic [7:0] image_byte(input logic [ADDR_W-1:0] ba);
        bit [WORD_W-1:0] w;
        w = ram_image[ba[ADDR_W-1:2]];
        return w[(3 - ba[1:0]) * 8 +: 8];
    endfunction

    task automatic set_image_byte(input logic [ADDR_W-1:0] ba, input logic [7:0] v);
        ram_image[ba[ADDR_W-1:2]][(3 - ba[1:0]) * 8 +: 8] = v;
    endtask

    task automatic apply_access(
        input  func_t             f,
        input  acc_width_t        aw,
        input  logic [ADDR_W-1:0] a,
        input  logic [CNT_W-1:0]  c,
        input  logic [DATA_W-1:0] d,
        output logic [DATA_W-1:0] rd
    );
        int                n;
        int                k;
        logic [ADDR_W-1:0] ba;
        logic [WIDX_W-1:0] wi;
        rd = '0;
        case (aw)
            AW_VAR:
            begin
                n = (c > MAX_ACCESS_BYTES) ? MAX_ACCESS_BYTES : int'(c);
                for (k = 0; k < n; k++)
                begin
                    ba = a + ADDR_W'(k);
                    if (f == FUNC_WRITE)
                        set_image_byte(ba, d[(n - 1 - k) * 8 +: 8]);
                    else
                        rd = {rd[DATA_W-9:0], image_byte(ba)};
                end
            end
            AW_BYTE:
            begin
                if (f == FUNC_WRITE)
                    set_image_byte(a, d[7:0]);
                else
                    rd = DATA_W'(image_byte(a));
            end
            AW_HALF:
            begin
                wi = a[WIDX_W:1];
                if (a[0] == 1'b0)
                begin
                    if (f == FUNC_WRITE)
                        ram_image[wi][31:16] = d[15:0];
                    else
                        rd = DATA_W'(ram_image[wi][31:16]);
                end
                else
                begin
                    if (f == FUNC_WRITE)
                        ram_image[wi][15:0] = d[15:0];
                    else
                        rd = DATA_W'(ram_image[wi][15:0]);
                end
            end
            default:
            begin
                wi = a[WIDX_W-1:0];
                if (f == FUNC_WRITE)
                    ram_image[wi] = d[WORD_W-1:0];
                else
                    rd = DATA_W'(ram_image[wi]);
            end
        endcase
    endtask

    initial
    begin
        fail_count      = 0;
        pending         = 0;
        results_checked = 0;
    end

    always @(posedge clk)
    begin
        logic [DATA_W-1:0] rd;
        logic [DATA_W-1:0] want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_reads.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected read word: read_data %h", read_data);
                    fail_count++;
                end
                else
                begin
                    want = expected_reads.pop_front();
                    results_checked++;
                    if (read_data !== want)
                    begin
                        if (fail_count < 10)
                            $display("read_data mismatch: expected %h, got %h",
                                     want, read_data);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                apply_access(func_t'(func), acc_width_t'(access_width), address,
                             byte_count, write_data, rd);
                if (func == FUNC_READ)
                    expected_reads.push_back(rd);
            end
            pending = expected_reads.size();
        end
    end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the big-endian variable-width RAM.
// ----------------------------------------------------------------------------
// A directed opening covers the address extremes, every access width, wrap
// past the last word, three-word variable accesses, and zero and oversized
// byte counts. Random words follow. They mostly land on a pool of hot words,
// and a read that would touch a never-written byte is sent as a write. Both
// channels idle at random. One long receiver stall fills the block, one
// burst runs with no idling, and the sender drains once in mid-run. The
// checker beside the block predicts every read.
// ----------------------------------------------------------------------------
module testbench;
    import bevwr_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_WORDS  = 1580;
    localparam int HOT_WORDS     = 48;
    localparam int STALL_AT      = 300;
    localparam int STALL_CYCLES  = 400;
    localparam int BURST_FIRST   = 500;
    localparam int BURST_LAST    = 700;
    localparam int DRAIN_AT      = 800;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic                func;
    logic [1:0]          access_width;
    logic [ADDR_W-1:0]   address;
    logic [CNT_W-1:0]    byte_count;
    logic [DATA_W-1:0]   write_data;
    logic                out_valid;
    logic                out_ready;
    logic [DATA_W-1:0]   read_data;

    int                  fail_count;
    int                  pending;
    int                  results_checked;
    int                  cycle_count;
    int                  words_sent;
    int                  reads_sent;
    int                  writes_sent;
    int                  width_sent [4];
    bit                  burst;
    bit   [WIDX_W-1:0]   hot_widx [HOT_WORDS];
    bit                  byte_valid [0:(1 << ADDR_W) - 1];

    big_endian_variable_width_ram_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .access_width (access_width),
        .address      (address),
        .byte_count   (byte_count),
        .write_data   (write_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_data    (read_data)
    );

    bevwr_check u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .access_width    (access_width),
        .address         (address),
        .byte_count      (byte_count),
        .write_data      (write_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .read_data       (read_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked)
    );

    initial
        clk = 1'b0;

    always #1 clk = ~clk;

    initial
        cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", CYCLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic void span_bytes(
        input  acc_width_t        aw,
        input  logic [ADDR_W-1:0] a,
        input  logic [CNT_W-1:0]  c,
        output logic [ADDR_W-1:0] first,
        output int                n
    );
        case (aw)
            AW_VAR:
            begin
                first = a;
                n     = (c > MAX_ACCESS_BYTES) ? MAX_ACCESS_BYTES : int'(c);
            end
            AW_BYTE:
            begin
                first = a;
                n     = 1;
            end
            AW_HALF:
            begin
                first = {a[ADDR_W-2:0], 1'b0};
                n     = 2;
            end
            default:
            begin
                first = {a[WIDX_W-1:0], 2'b00};
                n     = 4;
            end
        endcase
    endfunction

    function automatic bit span_written(
        input acc_width_t        aw,
        input logic [ADDR_W-1:0] a,
        input logic [CNT_W-1:0]  c
    );
        logic [ADDR_W-1:0] first;
        logic [ADDR_W-1:0] ba;
        int                n;
        int                k;
        span_bytes(aw, a, c, first, n);
        for (k = 0; k < n; k++)
        begin
            ba = first + ADDR_W'(k);
            if (!byte_valid[ba])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_word(
        input func_t             f,
        input acc_width_t        aw,
        input logic [ADDR_W-1:0] a,
        input logic [CNT_W-1:0]  c,
        input logic [DATA_W-1:0] d
    );
        logic [ADDR_W-1:0] first;
        logic [ADDR_W-1:0] ba;
        int                n;
        int                k;
        int                gap;
        func         <= f;
        access_width <= aw;
        address      <= a;
        byte_count   <= c;
        write_data   <= d;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
        width_sent[aw]++;
        if (f == FUNC_WRITE)
        begin
            writes_sent++;
            span_bytes(aw, a, c, first, n);
            for (k = 0; k < n; k++)
            begin
                ba = first + ADDR_W'(k);
                byte_valid[ba] = 1'b1;
            end
        end
        else
            reads_sent++;
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_random_word();
        bit   [WIDX_W-1:0] w;
        acc_width_t        aw;
        logic [ADDR_W-1:0] a;
        logic [CNT_W-1:0]  c;
        func_t             f;
        if ($urandom_range(0, 99) < 80)
            w = hot_widx[$urandom_range(0, HOT_WORDS - 1)];
        else
            w = WIDX_W'($urandom);
        aw = acc_width_t'($urandom_range(0, 3));
        case (aw)
            AW_VAR, AW_BYTE: a = {w, 2'($urandom)};
            AW_HALF:         a = {1'($urandom), w, 1'($urandom)};
            default:         a = {2'($urandom), w};
        endcase
        c = CNT_W'($urandom_range(1, MAX_ACCESS_BYTES));
        if ($urandom_range(0, 9) == 0)
            c = CNT_W'($urandom);
        f = ($urandom_range(0, 99) < 50) ? FUNC_READ : FUNC_WRITE;
        if (f == FUNC_READ && !span_written(aw, a, c))
            f = FUNC_WRITE;
        send_word(f, aw, a, c, {$urandom, $urandom});
    endtask

    initial
    begin
        int hold_left;
        bit stalled;
        hold_left = 0;
        stalled   = 1'b0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!stalled && words_sent >= STALL_AT)
            begin
                stalled   = 1'b1;
                hold_left = STALL_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (burst || $urandom_range(0, 99) < 60)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                hold_left = ($urandom_range(0, 99) < 93) ? $urandom_range(0, 2)
                                                         : $urandom_range(10, 40);
            end
        end
    end

    initial
    begin
        int i;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        func         = FUNC_READ;
        access_width = AW_VAR;
        address      = '0;
        byte_count   = '0;
        write_data   = '0;
        burst        = 1'b0;
        words_sent   = 0;
        reads_sent   = 0;
        writes_sent  = 0;
        for (i = 0; i < 4; i++)
            width_sent[i] = 0;
        hot_widx[0] = 16'h0000;
        hot_widx[1] = 16'h0001;
        hot_widx[2] = 16'h0002;
        hot_widx[3] = 16'hFFFF;
        hot_widx[4] = 16'hFFFE;
        for (i = 5; i < HOT_WORDS; i++)
            hot_widx[i] = WIDX_W'($urandom);

        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_word(FUNC_WRITE, AW_WORD, 18'h00000, 4'd0,  64'hFFFF_FFFF_0123_4567);
        send_word(FUNC_WRITE, AW_WORD, 18'h3FFFF, 4'd0,  64'h0000_0000_89AB_CDEF);
        send_word(FUNC_WRITE, AW_WORD, 18'h00001, 4'd0,  64'hA5A5_A5A5_DEAD_BEEF);
        send_word(FUNC_READ,  AW_VAR,  18'h3FFFE, 4'd8,  64'h0);
        send_word(FUNC_WRITE, AW_VAR,  18'h3FFFF, 4'd8,  64'hFFEE_DDCC_BBAA_9988);
        send_word(FUNC_READ,  AW_VAR,  18'h3FFFF, 4'd8,  64'h0);
        send_word(FUNC_READ,  AW_VAR,  18'h12345, 4'd0,  64'h0);
        send_word(FUNC_WRITE, AW_VAR,  18'h00001, 4'd15, 64'h1122_3344_5566_7788);
        send_word(FUNC_READ,  AW_VAR,  18'h00001, 4'd9,  64'h0);
        send_word(FUNC_WRITE, AW_BYTE, 18'h3FFFE, 4'd0,  64'hFFFF_FFFF_FFFF_FF5A);
        send_word(FUNC_READ,  AW_BYTE, 18'h3FFFE, 4'd0,  64'h0);
        send_word(FUNC_WRITE, AW_HALF, 18'h3FFFF, 4'd0,  64'hFFFF_0000_0000_C3D2);
        send_word(FUNC_READ,  AW_HALF, 18'h1FFFF, 4'd0,  64'h0);
        send_word(FUNC_READ,  AW_HALF, 18'h00000, 4'd0,  64'h0);
        send_word(FUNC_WRITE, AW_VAR,  18'h00004, 4'd0,  64'hFFFF_FFFF_FFFF_FFFF);
        send_word(FUNC_READ,  AW_VAR,  18'h00003, 4'd1,  64'h0);
        send_word(FUNC_READ,  AW_WORD, 18'h10000, 4'd0,  64'h0);
        send_word(FUNC_WRITE, AW_WORD, 18'h00002, 4'd0,  64'hFFFF_FFFF_FFFF_FFFF);
        send_word(FUNC_READ,  AW_WORD, 18'h20002, 4'd0,  64'h0);
        send_word(FUNC_READ,  AW_BYTE, 18'h00000, 4'd0,  64'h0);
        send_word(FUNC_READ,  AW_VAR,  18'h00006, 4'd4,  64'h0);

        for (i = 0; i < RANDOM_WORDS; i++)
        begin
            burst = (i >= BURST_FIRST && i < BURST_LAST);
            if (i == DRAIN_AT)
            begin
                in_valid <= 1'b0;
                while (pending != 0)
                    @(negedge clk);
            end
            send_random_word();
        end

        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("Accesses: %0d (%0d reads, %0d writes); variable %0d, byte %0d, half %0d, word %0d",
                 words_sent, reads_sent, writes_sent,
                 width_sent[AW_VAR], width_sent[AW_BYTE], width_sent[AW_HALF],
                 width_sent[AW_WORD]);
        $display("Read results checked: %0d, including wrap past the last word and a full stall",
                 results_checked);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
